/* sv/fip_pkg.sv */
// Shared types and constants for the integer-power block.
// Used by fip_fpu and float_integer_power; no dependencies.
package fip_pkg;

  localparam int unsigned EXP_BITS_DEF = 32;

  // binary64 constants
  localparam logic [63:0] DBL_ONE      = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] DBL_NAN_DEF  = 64'hFFF8_0000_0000_0000;
  localparam logic [10:0] EXP_MAX      = 11'h7FF;
  localparam int unsigned QUIET_BIT    = 51;

  typedef enum logic [1:0] {
    OP_MUL   = 2'b01,
    OP_RECIP = 2'b10
  } fpu_op_t;

  typedef struct packed {
    logic    start;
    fpu_op_t op;
  } fpu_req_t;

endpackage

/* sv/fip_fpu.sv */
// Iterative binary64 unit: multiply (four 27x27 partial products) or reciprocal
// (restoring divide, one quotient bit a cycle), shared normalize and RNE round.
// Depends on fip_pkg.
module fip_fpu (
  input  logic              clk,
  input  logic              rst,
  input  fip_pkg::fpu_req_t req,
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  output logic              done,
  output logic [63:0]       res
);
  import fip_pkg::*;

  localparam int unsigned Q_BITS = 56;
  localparam int unsigned P_W    = 106;

  typedef enum logic [6:0] {
    F_IDLE = 7'b0000001,
    F_PROD = 7'b0000010,
    F_DIVN = 7'b0000100,
    F_DIV  = 7'b0001000,
    F_NORM = 7'b0010000,
    F_SHR  = 7'b0100000,
    F_RND  = 7'b1000000
  } fstate_t;

  fstate_t            st;
  logic               sgn;
  logic signed [13:0] e;
  logic [P_W-1:0]     p;
  logic               stk;
  logic [52:0]        ma, mb;
  logic [53:0]        rem;
  logic [5:0]         cnt;

  // operand decode
  logic [10:0] ea, eb;
  logic [51:0] fa, fb;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  always_comb begin
    ea     = a[62:52];
    eb     = b[62:52];
    fa     = a[51:0];
    fb     = b[51:0];
    nan_a  = (ea == EXP_MAX) && (fa != '0);
    nan_b  = (eb == EXP_MAX) && (fb != '0);
    inf_a  = (ea == EXP_MAX) && (fa == '0);
    inf_b  = (eb == EXP_MAX) && (fb == '0);
    zero_a = (ea == '0) && (fa == '0);
    zero_b = (eb == '0) && (fb == '0);
  end

  logic signed [13:0] ea_eff, eb_eff;
  assign ea_eff = (ea == '0) ? 14'sd1 : $signed({3'b000, ea});
  assign eb_eff = (eb == '0) ? 14'sd1 : $signed({3'b000, eb});

  // partial product of one half pair
  logic [26:0] ah, bh;
  logic [53:0] pp;
  logic [6:0]  sh;
  always_comb begin
    ah = cnt[1] ? ma[52:26] : {1'b0, ma[25:0]};
    bh = cnt[0] ? mb[52:26] : {1'b0, mb[25:0]};
    pp = ah * bh;
    sh = (cnt[1] ? 7'd26 : 7'd0) + (cnt[0] ? 7'd26 : 7'd0);
  end

  // divide step
  logic        qbit;
  logic [53:0] rem_sub;
  always_comb begin
    qbit    = rem >= {1'b0, mb};
    rem_sub = qbit ? (rem - {1'b0, mb}) : rem;
  end

  // denormal alignment
  logic [13:0]    amt;
  logic [P_W-1:0] shr_mask;
  assign amt      = 14'(14'sd1 - e);
  assign shr_mask = ~({P_W{1'b1}} << amt[6:0]);

  // rounding
  logic        rinc;
  logic [53:0] m54;
  logic [52:0] mant;
  logic signed [13:0] efin;
  logic [10:0] efield;
  always_comb begin
    rinc = p[51] & (stk | (|p[50:0]) | p[52]);
    m54  = {1'b0, p[104:52]} + 54'(rinc);
    if (m54[53]) begin
      mant = {1'b1, 52'b0};
      efin = e + 14'sd1;
    end else begin
      mant = m54[52:0];
      efin = e;
    end
    efield = mant[52] ? efin[10:0] : 11'd0;
  end

  logic [P_W-1:0] qshift;
  assign qshift = {p[P_W-2:0], qbit} << 49;

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= F_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        F_IDLE: begin
          if (req.start) begin
            stk <= 1'b0;
            cnt <= '0;
            p   <= '0;
            if (req.op == OP_MUL) begin
              sgn <= a[63] ^ b[63];
              if (nan_a) begin
                res <= a | (64'd1 << QUIET_BIT); done <= 1'b1;
              end else if (nan_b) begin
                res <= b | (64'd1 << QUIET_BIT); done <= 1'b1;
              end else if ((inf_a && zero_b) || (zero_a && inf_b)) begin
                res <= DBL_NAN_DEF; done <= 1'b1;
              end else if (inf_a || inf_b) begin
                res <= {a[63] ^ b[63], EXP_MAX, 52'b0}; done <= 1'b1;
              end else if (zero_a || zero_b) begin
                res <= {a[63] ^ b[63], 63'b0}; done <= 1'b1;
              end else begin
                ma <= {ea != '0, fa};
                mb <= {eb != '0, fb};
                e  <= ea_eff + eb_eff - 14'sd1023;
                st <= F_PROD;
              end
            end else begin
              sgn <= b[63];
              if (nan_b) begin
                res <= b | (64'd1 << QUIET_BIT); done <= 1'b1;
              end else if (inf_b) begin
                res <= {b[63], 63'b0}; done <= 1'b1;
              end else if (zero_b) begin
                res <= {b[63], EXP_MAX, 52'b0}; done <= 1'b1;
              end else begin
                mb <= {eb != '0, fb};
                e  <= eb_eff;
                st <= F_DIVN;
              end
            end
          end
        end
        // accumulate partial products
        F_PROD: begin
          p   <= p + ({52'b0, pp} << sh);
          cnt <= cnt + 6'd1;
          if (cnt == 6'd3) st <= F_NORM;
        end
        // normalize divisor, then set result exponent
        F_DIVN: begin
          if (!mb[52]) begin
            mb <= {mb[51:0], 1'b0};
            e  <= e - 14'sd1;
          end else begin
            e   <= 14'sd2046 - e;
            rem <= 54'd1 << 52;
            st  <= F_DIV;
          end
        end
        F_DIV: begin
          rem <= {rem_sub[52:0], 1'b0};
          cnt <= cnt + 6'd1;
          if (cnt == 6'(Q_BITS - 1)) begin
            p   <= qshift;
            stk <= rem_sub != '0;
            st  <= F_NORM;
          end else begin
            p <= {p[P_W-2:0], qbit};
          end
        end
        // one bit per cycle toward the leading one
        F_NORM: begin
          if (p[105]) begin
            p   <= p >> 1;
            stk <= stk | p[0];
            e   <= e + 14'sd1;
          end else if (!p[104] && (e > 14'sd1)) begin
            p <= p << 1;
            e <= e - 14'sd1;
          end else if (e < 14'sd1) begin
            st <= F_SHR;
          end else begin
            st <= F_RND;
          end
        end
        F_SHR: begin
          if (amt >= 14'd107) begin
            stk <= stk | (|p);
            p   <= '0;
          end else begin
            stk <= stk | (|(p & shr_mask));
            p   <= p >> amt[6:0];
          end
          e  <= 14'sd1;
          st <= F_RND;
        end
        F_RND: begin
          if (efin >= 14'sd2047) res <= {sgn, EXP_MAX, 52'b0};
          else                   res <= {sgn, efield, mant[51:0]};
          done <= 1'b1;
          st   <= F_IDLE;
        end
        default: st <= F_IDLE;
      endcase
    end
  end

endmodule

/* sv/float_integer_power.sv */
// Binary64 base raised to a signed integer power, MSB-first square-and-multiply.
// A negative power first takes the reciprocal of the base. After the first set bit, each
// exponent bit scanned costs a square, and each set bit costs a multiply; subnormal
// operands add normalize shifts in the unit.
// One beat in flight: in_ready drops until done.
// One shared multiply/divide unit does all the arithmetic. Sync reset clears control only.
module float_integer_power #(
  parameter int unsigned EXP_BITS = fip_pkg::EXP_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [63:0]         base_bits,
  input  logic [EXP_BITS-1:0] power,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [63:0]         result_bits
);
  import fip_pkg::*;

  localparam int unsigned IDX_W = $clog2(EXP_BITS);

  typedef enum logic [6:0] {
    T_IDLE  = 7'b0000001,
    T_RECIP = 7'b0000010,
    T_BIT   = 7'b0000100,
    T_SQR   = 7'b0001000,
    T_TST   = 7'b0010000,
    T_MUL   = 7'b0100000,
    T_FIN   = 7'b1000000
  } tstate_t;

  tstate_t             state;
  logic [63:0]         base, r;
  logic [EXP_BITS-1:0] mag;
  logic [IDX_W-1:0]    idx;
  logic                started;

  fpu_req_t    req;
  logic [63:0] fpu_b;
  logic        fpu_done;
  logic [63:0] fpu_res;

  logic accept;
  assign in_ready = (state == T_IDLE);
  assign accept   = in_valid && in_ready;

  // unit request and operand select
  always_comb begin
    req.start = 1'b0;
    req.op    = OP_MUL;
    fpu_b     = base;
    unique case (state)
      T_IDLE: begin
        req.start = accept && power[EXP_BITS-1];
        req.op    = OP_RECIP;
        fpu_b     = base_bits;
      end
      T_BIT: begin
        req.start = started;
        fpu_b     = r;
      end
      T_TST: req.start = mag[idx];
      default: ;
    endcase
  end

  fip_fpu u_fpu (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .a    (r),
    .b    (fpu_b),
    .done (fpu_done),
    .res  (fpu_res)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      out_valid <= 1'b0;
      started   <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            base    <= base_bits;
            r       <= DBL_ONE;
            started <= 1'b0;
            idx     <= IDX_W'(EXP_BITS - 1);
            if (power[EXP_BITS-1]) begin
              mag   <= '0 - power;
              state <= T_RECIP;
            end else begin
              mag   <= power;
              state <= T_BIT;
            end
          end
        end
        T_RECIP: begin
          if (fpu_done) begin
            base  <= fpu_res;
            state <= T_BIT;
          end
        end
        T_BIT: state <= started ? T_SQR : T_TST;
        T_SQR: begin
          if (fpu_done) begin
            r     <= fpu_res;
            state <= T_TST;
          end
        end
        T_TST: begin
          if (mag[idx]) state <= T_MUL;
          else if (idx == '0) state <= T_FIN;
          else begin
            idx   <= idx - 1'b1;
            state <= T_BIT;
          end
        end
        T_MUL: begin
          if (fpu_done) begin
            r       <= fpu_res;
            started <= 1'b1;
            if (idx == '0) state <= T_FIN;
            else begin
              idx   <= idx - 1'b1;
              state <= T_BIT;
            end
          end
        end
        T_FIN: begin
          if (!out_valid || out_ready) begin
            result_bits <= r;
            out_valid   <= 1'b1;
            state       <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // unit finishes only while the sequencer waits on it
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    fpu_done |-> (state == T_RECIP || state == T_SQR || state == T_MUL))
    else $error("fpu done outside a wait state");

  // an accepted beat blocks the input until finished
  a_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("input ready right after accept");

  // a finished result waits while the output is held
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == T_FIN && out_valid && !out_ready) |=> state == T_FIN)
    else $error("result dropped while output stalled");

  // a completed multiply marks the accumulator started
  a_started: assert property (@(posedge clk) disable iff (rst)
    (state == T_MUL && fpu_done) |=> started)
    else $error("started flag not set");

endmodule

/* tb/float_integer_power_tb.sv */
// Testbench for float_integer_power: binary64 base raised to a signed integer power.
// Depends on fip_pkg and the float_integer_power RTL; self-checking through a
// bit-exact binary64 predictor (round to nearest even, subnormals, inf, NaN).
`timescale 1ns / 100ps

module float_integer_power_tb;
  import fip_pkg::*;

  localparam int unsigned PW_BITS    = 32;
  localparam int          N_RANDOM   = 1300;
  localparam int          IDLE_LIMIT = 40000;
  localparam int          LONG_HOLD  = 3000;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [63:0]         base_bits;
  logic [PW_BITS-1:0]  power;
  logic                out_valid;
  logic                out_ready;
  logic [63:0]         result_bits;

  logic [63:0] pending_results[$];
  int          n_fail;
  int          n_sent;
  int          n_checked;
  int          idle_cycles;
  logic        hold_request;
  logic        hold_done;

  typedef struct {
    logic [63:0]        base;
    logic [PW_BITS-1:0] pw;
    logic               typed;
    logic [63:0]        result;
  } power_row_t;

  power_row_t directed_rows[$];

  float_integer_power #(.EXP_BITS(PW_BITS)) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .base_bits  (base_bits),
    .power      (power),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_bits(result_bits)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic is_nan(input logic [63:0] x);
    return (x[62:52] == EXP_MAX) && (x[51:0] != 0);
  endfunction

  function automatic logic is_inf(input logic [63:0] x);
    return (x[62:52] == EXP_MAX) && (x[51:0] == 0);
  endfunction

  function automatic logic is_zero(input logic [63:0] x);
    return x[62:0] == 0;
  endfunction

  // Integer significand and power-of-two scale of a finite nonzero operand
  function automatic void split_finite(input logic [63:0] x, output logic [127:0] sig,
                                       output int scale);
    if (x[62:52] == 0) begin
      sig   = {76'b0, x[51:0]};
      scale = -1074;
    end else begin
      sig   = {75'b0, 1'b1, x[51:0]};
      scale = int'(x[62:52]) - 1075;
    end
  endfunction

  // Round sig * 2^scale (plus a sticky tail) to binary64, nearest even
  function automatic logic [63:0] round_to_double(input logic sgn, input int scale,
                                                  input logic [127:0] sig,
                                                  input logic tail);
    int           msb;
    int           shift;
    int           q;
    logic [127:0] kept;
    logic         guard;
    logic         rest;
    if (sig == 0) return {sgn, 63'b0};
    msb = 127;
    while (!sig[msb]) msb--;
    shift = msb - 52;
    if (msb + scale < -1022) shift = -1074 - scale;
    if (shift > 128) begin
      kept  = 0;
      guard = 1'b0;
      rest  = 1'b1;
    end else if (shift > 0) begin
      kept  = sig >> shift;
      guard = sig[shift-1];
      rest  = |(sig & ((128'b1 << (shift - 1)) - 1)) | tail;
    end else begin
      kept  = sig << (-shift);
      guard = 1'b0;
      rest  = tail;
    end
    q = scale + shift;
    if (guard && (rest || kept[0])) kept = kept + 1;
    if (kept == (128'b1 << 53)) begin
      kept = kept >> 1;
      q++;
    end
    if (kept < (128'b1 << 52)) return {sgn, 11'b0, kept[51:0]};
    if (q + 1075 >= 2047) return {sgn, EXP_MAX, 52'b0};
    return {sgn, 11'(q + 1075), kept[51:0]};
  endfunction

  // a * b; a NaN first operand wins
  function automatic logic [63:0] dbl_mul(input logic [63:0] a, input logic [63:0] b);
    logic         sgn;
    logic [127:0] sa, sb;
    int           ea, eb;
    sgn = a[63] ^ b[63];
    if (is_nan(a)) return a | (64'b1 << QUIET_BIT);
    if (is_nan(b)) return b | (64'b1 << QUIET_BIT);
    if (is_inf(a) || is_inf(b)) begin
      if (is_zero(a) || is_zero(b)) return DBL_NAN_DEF;
      return {sgn, EXP_MAX, 52'b0};
    end
    if (is_zero(a) || is_zero(b)) return {sgn, 63'b0};
    split_finite(a, sa, ea);
    split_finite(b, sb, eb);
    return round_to_double(sgn, ea + eb, sa * sb, 1'b0);
  endfunction

  // 1.0 / b, correctly rounded
  function automatic logic [63:0] dbl_recip(input logic [63:0] b);
    logic [127:0] sb, quo, rem;
    int           eb;
    if (is_nan(b)) return b | (64'b1 << QUIET_BIT);
    if (is_zero(b)) return {b[63], EXP_MAX, 52'b0};
    if (is_inf(b)) return {b[63], 63'b0};
    split_finite(b, sb, eb);
    quo = (128'b1 << 116) / sb;
    rem = (128'b1 << 116) % sb;
    return round_to_double(b[63], -116 - eb, quo, rem != 0);
  endfunction

  // MSB-first square-and-multiply from 1.0
  function automatic logic [63:0] predict_power(input logic [63:0] base,
                                                input logic [PW_BITS-1:0] pw);
    logic [63:0]        acc;
    logic [63:0]        b;
    logic [PW_BITS-1:0] mag;
    logic               started;
    acc     = DBL_ONE;
    b       = base;
    mag     = pw;
    started = 1'b0;
    if (pw[PW_BITS-1]) begin
      b   = dbl_recip(base);
      mag = -pw;
    end
    for (int i = PW_BITS - 1; i >= 0; i--) begin
      if (started) acc = dbl_mul(acc, acc);
      if (mag[i]) begin
        acc     = dbl_mul(acc, b);
        started = 1'b1;
      end
    end
    return acc;
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic add_row(input logic [63:0] b, input int p, input logic typed,
                         input logic [63:0] r);
    power_row_t row;
    row.base   = b;
    row.pw     = PW_BITS'(p);
    row.typed  = typed;
    row.result = r;
    directed_rows.push_back(row);
  endtask

  // Offer one beat and hold it until accepted; returns at the next falling edge
  task automatic send_beat(input logic [63:0] b, input logic [PW_BITS-1:0] p,
                           input logic typed, input logic [63:0] r);
    in_valid  <= 1'b1;
    base_bits <= b;
    power     <= p;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(typed ? r : predict_power(b, p));
    n_sent++;
    @(negedge clk);
  endtask

  // Burst/gap pacing after each beat
  int burst_left;
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 6);
    end
  endtask

  function automatic logic [63:0] random_base();
    logic [63:0] b;
    b = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1:    ;                                                   // any encoding
      2, 3, 4: b[62:52] = 11'h3FE + 11'($urandom_range(0, 1));     // near one
      5:       b[62:52] = 11'($urandom_range(1000, 1050));
      6:       b[62:52] = 11'h000;                                 // subnormal or zero
      7:       b[62:52] = ($urandom_range(0, 1) != 0) ? 11'h001 : 11'h7FE;
      8:       b[62:0]  = {EXP_MAX, ($urandom_range(0, 1) != 0) ? 52'b0 : b[51:0]};
      default: b[62:52] = 11'($urandom_range(900, 1150));
    endcase
    return b;
  endfunction

  function automatic logic [PW_BITS-1:0] random_power();
    logic [PW_BITS-1:0] p;
    case ($urandom_range(0, 9))
      0:       p = $urandom;
      1:       p = PW_BITS'($urandom_range(0, 2000)) - PW_BITS'(1000);
      default: p = PW_BITS'($urandom_range(0, 80)) - PW_BITS'(40);
    endcase
    if (p == {1'b1, {(PW_BITS - 1){1'b0}}}) p = p + 1;   // most negative is excluded
    return p;
  endfunction

  // Main sequence
  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    base_bits    = '0;
    power        = '0;
    n_fail       = 0;
    n_sent       = 0;
    n_checked    = 0;
    hold_request = 1'b0;
    burst_left   = 0;

    // Power zero, exact powers of two, signed zeros, infinities, NaNs, subnormals, extremes
    add_row(DBL_ONE,                0,           1, DBL_ONE);
    add_row(64'h7FF8_0000_0000_0001, 0,          1, DBL_ONE);
    add_row(64'hFFF0_0000_0000_0000, 0,          1, DBL_ONE);
    add_row(64'h4000_0000_0000_0000, 10,         1, 64'h4090_0000_0000_0000);
    add_row(64'h4000_0000_0000_0000, -1,         1, 64'h3FE0_0000_0000_0000);
    add_row(64'h0000_0000_0000_0000, -1,         1, 64'h7FF0_0000_0000_0000);
    add_row(64'h8000_0000_0000_0000, -1,         1, 64'hFFF0_0000_0000_0000);
    add_row(64'h8000_0000_0000_0000, -2,         1, 64'h7FF0_0000_0000_0000);
    add_row(64'h0000_0000_0000_0000, 5,          1, 64'h0000_0000_0000_0000);
    add_row(64'h8000_0000_0000_0000, 3,          1, 64'h8000_0000_0000_0000);
    add_row(64'h4000_0000_0000_0000, 1024,       1, 64'h7FF0_0000_0000_0000);
    add_row(64'h4000_0000_0000_0000, -1074,      1, 64'h0000_0000_0000_0001);
    add_row(64'h4000_0000_0000_0000, -1075,      0, '0);
    add_row(64'hBFF0_0000_0000_0000, 2147483647, 1, 64'hBFF0_0000_0000_0000);
    add_row(DBL_ONE,                -2147483647, 1, DBL_ONE);
    add_row(64'h7FF0_0000_0000_0000, -1,         1, 64'h0000_0000_0000_0000);
    add_row(64'hFFF0_0000_0000_0000, -1,         1, 64'h8000_0000_0000_0000);
    add_row(64'h7FF0_0000_0000_0000, 2,          1, 64'h7FF0_0000_0000_0000);
    add_row(64'h7FF0_0000_0000_0001, 1,          0, '0);   // signaling NaN is quieted
    add_row(64'hFFF8_0000_0000_0123, -3,         0, '0);
    add_row(64'h7FEF_FFFF_FFFF_FFFF, 1,          0, '0);
    add_row(64'h0000_0000_0000_0001, -1,         0, '0);
    add_row(64'h000F_FFFF_FFFF_FFFF, -1,         0, '0);
    add_row(64'h4008_0000_0000_0000, -1,         0, '0);
    add_row(64'h3FF8_0000_0000_0000, 30,         0, '0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table
    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].base, directed_rows[i].pw,
                directed_rows[i].typed, directed_rows[i].result);
      pace_sender();
    end

    // Random part; partway through, ask the receiver for one long hold
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == 300) hold_request = 1'b1;
      send_beat(random_base(), random_power(), 1'b0, '0);
      pace_sender();
    end
    in_valid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk);
    $display("Covered %0d beats (%0d directed) with %0d results checked,", n_sent,
             directed_rows.size(), n_checked);
    $display("including one long output hold and special operands.");
    if (n_fail == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver: stall pattern of its own, plus one long hold on request
  initial begin
    int mode_left;
    int hold_left;
    logic mode_busy;
    out_ready = 1'b0;
    hold_done = 1'b0;
    mode_left = 0;
    hold_left = 0;
    mode_busy = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode_busy = ($urandom_range(0, 2) != 0);
        mode_left = $urandom_range(10, 200);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (mode_busy) begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Result checker and idle watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time,
                   result_bits);
          n_fail++;
        end else begin
          if (result_bits !== pending_results[0]) begin
            $display("%0t: result_bits mismatch, expected %h, actual %h", $time,
                     pending_results[0], result_bits);
            n_fail++;
          end
          void'(pending_results.pop_front());
          n_checked++;
        end
      end
      if ((out_valid && out_ready) || (in_valid && in_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
          $display("Simulation FAILED");
          $finish;
        end
      end
    end else begin
      idle_cycles = 0;
    end
  end

endmodule

/* float_integer_power.f */
sv/fip_pkg.sv
sv/fip_fpu.sv
sv/float_integer_power.sv
tb/float_integer_power_tb.sv
